/* hdl/garhm_pkg.sv */
// ----------------------------------------------------------------------------
// garhm_pkg
// shared widths, register indexes and reset values for the gated
// attack/release height map
// ----------------------------------------------------------------------------
`default_nettype none

package garhm_pkg;

  // default cell store depth
  localparam int DEF_MAX_CELLS = 4096;

  // field and register widths
  localparam int SAMPLE_W = 8;
  localparam int MOTION_W = 16;
  localparam int THRESH_W = 15;
  localparam int SCALE_W  = 17;
  localparam int GAIN_W   = 12;
  localparam int RATE_W   = 16;
  localparam int CNT_W    = 13;
  localparam int HEIGHT_W = 16;
  localparam int SUM_W    = 28;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_GATE_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] CFG_GATE_SCALE     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_RISE_RATE      = 3'd3;
  localparam logic [IDX_W-1:0] CFG_FALL_RATE      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_CELL_COUNT     = 3'd5;

  // register reset values
  localparam logic [THRESH_W-1:0] RST_GATE_THRESHOLD = 15'd9830;
  localparam logic [SCALE_W-1:0]  RST_GATE_SCALE     = 17'd77101;
  localparam logic [GAIN_W-1:0]   RST_HEIGHT_GAIN    = 12'd256;
  localparam logic [RATE_W-1:0]   RST_RISE_RATE      = 16'd19661;
  localparam logic [RATE_W-1:0]   RST_FALL_RATE      = 16'd3277;
  localparam logic [CNT_W-1:0]    RST_CELL_COUNT     = 13'd4096;

  // lowest height shown, and the value of a never-written cell (0.1 in q8.8)
  localparam logic [HEIGHT_W-1:0] HEIGHT_FLOOR = 16'd26;

endpackage

`default_nettype wire

/* hdl/gated_attack_release_height_map_core.sv */
// ----------------------------------------------------------------------------
// gated_attack_release_height_map_core
// noise-gated motion to per-cell height map with attack/release smoothing
// ----------------------------------------------------------------------------
// sequence: an accepted word steps through the gate, target, difference, step and
//   write-back states to the output register, and on the frame's last cell waits
//   on the 28-step average divider; no new word is taken until then, a limit set by
//   the read-modify-write pass through the height ram and its multiplier chain
// reset: registers take their reset values, position and sum clear, and a
//   fill count makes every height read as 0.1 until written; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module gated_attack_release_height_map_core
  import garhm_pkg::*;
#(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // sample words
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_motion_sample,
  // result words
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [HEIGHT_W-1:0] out_column_height,
  output logic                     out_frame_done,
  output logic      [MOTION_W-1:0] out_average_motion,
  // register writes
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  // position index and fill count widths follow the store depth
  localparam int PW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int FW = $clog2(MAX_CELLS + 1);

  // sequencer states: one word walks through these in order, DIV on a frame's last cell only
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a word, issue ram read
  localparam logic [2:0] ST_GATE = 3'd1;  // capture height, gate scale multiply
  localparam logic [2:0] ST_TGT  = 3'd2;  // gain multiply, accumulate sum
  localparam logic [2:0] ST_DIFF = 3'd3;  // target, direction, difference
  localparam logic [2:0] ST_STEP = 3'd4;  // rate multiply
  localparam logic [2:0] ST_WB   = 3'd5;  // new height, ram write back
  localparam logic [2:0] ST_DIV  = 3'd6;  // wait on frame average divide
  localparam logic [2:0] ST_OUT  = 3'd7;  // hand result to output register

  // configuration registers
  logic [THRESH_W-1:0] thresh_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [RATE_W-1:0]   rise_r;
  logic [RATE_W-1:0]   fall_r;
  logic [CNT_W-1:0]    count_r;
  logic                clear_req;

  // sequencer and frame state
  logic [2:0]          state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                last_r, last_nxt;

  // datapath registers
  logic [MOTION_W-1:0] diff_r, diff_nxt;
  logic [MOTION_W-1:0] g_r, g_nxt;
  logic [HEIGHT_W-1:0] h_r, h_nxt;
  logic [27:0]         gp_r, gp_nxt;
  logic signed [16:0]  d_r, d_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic signed [33:0]  prod_r, prod_nxt;
  logic [HEIGHT_W-1:0] hgt_r, hgt_nxt;
  logic [MOTION_W-1:0] avg_r, avg_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [HEIGHT_W-1:0] out_hgt_r, out_hgt_nxt;
  logic                out_done_r, out_done_nxt;
  logic [MOTION_W-1:0] out_avg_r, out_avg_nxt;

  // combinational helpers
  logic                in_acc;
  logic                out_free;
  logic [CNT_W-1:0]    cells;
  logic [MOTION_W-1:0] m_wide;
  logic [32:0]         gmul;
  logic [31:0]         t15;
  logic [HEIGHT_W-1:0] target;
  logic signed [16:0]  rate_s;
  logic signed [17:0]  step_s;
  logic signed [17:0]  nh_s;
  logic [HEIGHT_W-1:0] nh;
  logic                is_last;

  // ram and divider hookup
  logic                ram_we;
  logic [HEIGHT_W-1:0] ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  assign clear_req = cfg_we && (cfg_index == CFG_CELL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= RST_GATE_THRESHOLD;
      scale_r  <= RST_GATE_SCALE;
      gain_r   <= RST_HEIGHT_GAIN;
      rise_r   <= RST_RISE_RATE;
      fall_r   <= RST_FALL_RATE;
      count_r  <= RST_CELL_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GATE_THRESHOLD: thresh_r <= cfg_data[THRESH_W-1:0];
        CFG_GATE_SCALE:     scale_r  <= cfg_data[SCALE_W-1:0];
        CFG_HEIGHT_GAIN:    gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_RISE_RATE:      rise_r   <= cfg_data[RATE_W-1:0];
        CFG_FALL_RATE:      fall_r   <= cfg_data[RATE_W-1:0];
        CFG_CELL_COUNT:     count_r  <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // cell count held to 1 .. MAX_CELLS
  always_comb begin
    if (count_r == '0) begin
      cells = CNT_W'(1);
    end else if (32'(count_r) > 32'(MAX_CELLS)) begin
      cells = CNT_W'(MAX_CELLS);
    end else begin
      cells = count_r;
    end
  end

  // ---------------------------------------------------------------------------
  // height store: one entry per cell, read ahead of the write-back update
  // ---------------------------------------------------------------------------

  garhm_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAX_CELLS)
  ) u_heights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (nh),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // frame average: sum over cells, truncated
  garhm_div u_avg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cells),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // datapath arithmetic
  // ---------------------------------------------------------------------------

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // sample times 257 is the byte repeated
  assign m_wide = {in_motion_sample, in_motion_sample};

  // part above the gate, rescaled to full range
  assign gmul = 33'(diff_r) * 33'(scale_r);

  // target = (g * gain * 15) >> 16, times 15 as a shift and subtract
  assign t15    = {gp_r, 4'b0000} - 32'(gp_r);
  assign target = t15[31:16];

  // rate product shifted down with rounding toward minus infinity
  assign rate_s = $signed({1'b0, rate_r});
  assign step_s = prod_r[33:16];
  assign nh_s   = $signed({2'b00, h_r}) + step_s;

  always_comb begin
    if (nh_s[17]) begin
      nh = '0;
    end else if (nh_s[16]) begin
      nh = '1;
    end else begin
      nh = nh_s[15:0];
    end
  end

  assign is_last = (32'(pos_r) + 32'd1) >= 32'(cells);

  assign ram_we    = (state_r == ST_WB);
  assign div_start = (state_r == ST_WB) && is_last;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    last_nxt      = last_r;
    diff_nxt      = diff_r;
    g_nxt         = g_r;
    h_nxt         = h_r;
    gp_nxt        = gp_r;
    d_nxt         = d_r;
    rate_nxt      = rate_r;
    prod_nxt      = prod_r;
    hgt_nxt       = hgt_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hgt_nxt   = out_hgt_r;
    out_done_nxt  = out_done_r;
    out_avg_nxt   = out_avg_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // noise gate: keep only what rises above the threshold
          if (m_wide > {1'b0, thresh_r}) begin
            diff_nxt = m_wide - {1'b0, thresh_r};
          end else begin
            diff_nxt = '0;
          end
          state_nxt = ST_GATE;
        end
      end
      ST_GATE: begin
        // cells past the fill count were never written since the last clear
        h_nxt = (FW'(pos_r) < fill_r) ? ram_rdata : HEIGHT_FLOOR;
        g_nxt = gmul[32] ? '1 : gmul[31:16];
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        gp_nxt    = 28'(g_r) * 28'(gain_r);
        sum_nxt   = sum_r + SUM_W'(g_r);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        // attack when the target is above the stored height, release otherwise
        rate_nxt  = (target > h_r) ? rise_r : fall_r;
        d_nxt     = $signed({1'b0, target}) - $signed({1'b0, h_r});
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        prod_nxt  = d_r * rate_s;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        hgt_nxt  = (nh < HEIGHT_FLOOR) ? HEIGHT_FLOOR : nh;
        last_nxt = is_last;
        if (FW'(pos_r) == fill_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (is_last) begin
          pos_nxt   = '0;
          sum_nxt   = '0;  // divider has latched the frame sum
          state_nxt = ST_DIV;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt   = div_quo[MOTION_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hgt_nxt   = hgt_r;
          out_done_nxt  = last_r;
          out_avg_nxt   = last_r ? avg_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a cell count write restarts the frame and empties the store
    if (clear_req) begin
      pos_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    diff_r    <= diff_nxt;
    g_r       <= g_nxt;
    h_r       <= h_nxt;
    gp_r      <= gp_nxt;
    d_r       <= d_nxt;
    rate_r    <= rate_nxt;
    prod_r    <= prod_nxt;
    hgt_r     <= hgt_nxt;
    avg_r     <= avg_nxt;
    out_hgt_r <= out_hgt_nxt;
    out_done_r <= out_done_nxt;
    out_avg_r <= out_avg_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_column_height  = out_hgt_r;
  assign out_frame_done     = out_done_r;
  assign out_average_motion = out_avg_r;

endmodule

`default_nettype wire

/* hdl/garhm_ram.sv */
// ----------------------------------------------------------------------------
// garhm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module garhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/garhm_div.sv */
// ----------------------------------------------------------------------------
// garhm_div
// restoring divider, one quotient bit per cycle, for the frame average
// ----------------------------------------------------------------------------
`default_nettype none

module garhm_div
  import garhm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* verif/tb_gated_attack_release_height_map_core.sv */
// ----------------------------------------------------------------------------
// tb_gated_attack_release_height_map_core
// self-checking bench for the gated attack/release height map: a bit-exact
// predictor of the gate, gain, smoothing and frame average runs beside the
// core, every result word is compared field by field with the oldest
// prediction, and both channels idle in random bursts
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gated_attack_release_height_map_core;
  import garhm_pkg::*;

  localparam int MAX_CELLS      = DEF_MAX_CELLS;
  localparam int RANDOM_ITEMS   = 450;
  localparam int QUIET_ITEMS    = 100;   // closing stretch with no idling
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no accept before giving up
  localparam int TAIL_CYCLES    = 60;    // covers the slow last-cell divide

  // register indexes the core does not decode
  localparam logic [IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  // one result word as the core presents it
  typedef struct packed {
    logic [HEIGHT_W-1:0] column_height;
    logic                frame_done;
    logic [MOTION_W-1:0] average_motion;
  } height_word_t;

  // clock, reset and ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_motion_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HEIGHT_W-1:0] out_column_height;
  logic                out_frame_done;
  logic [MOTION_W-1:0] out_average_motion;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  // predictor copy of the registers
  logic [THRESH_W-1:0] gate_level;
  logic [SCALE_W-1:0]  gate_gain_scale;
  logic [GAIN_W-1:0]   height_mult;
  logic [RATE_W-1:0]   rise_frac;
  logic [RATE_W-1:0]   fall_frac;
  logic [CNT_W-1:0]    cells_reg;

  // predictor copy of the state
  logic [HEIGHT_W-1:0] height_store [MAX_CELLS];
  int unsigned         cell_pos;
  logic [SUM_W-1:0]    gated_total;

  // heights still owed by the core, oldest first
  height_word_t expected_heights [$];

  bit idle_on = 1'b0;   // random stalls on both sides
  int mismatches = 0;
  int words_checked = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  gated_attack_release_height_map_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_motion_sample   (in_motion_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_column_height  (out_column_height),
    .out_frame_done     (out_frame_done),
    .out_average_motion (out_average_motion),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // every cell back to 0.1, frame restarts
  function automatic void clear_heights();
    for (int i = 0; i < MAX_CELLS; i++) height_store[i] = HEIGHT_FLOOR;
    cell_pos = 0;
    gated_total = '0;
  endfunction

  // cell count as the core uses it: zero acts as one, big values as the depth
  function automatic int unsigned frame_length();
    if (cells_reg == 0) return 1;
    if (cells_reg > MAX_CELLS) return MAX_CELLS;
    return cells_reg;
  endfunction

  // next result word for one motion byte, updating the predicted state
  function automatic height_word_t predict_height(input logic [SAMPLE_W-1:0] motion);
    height_word_t    w;
    int unsigned     cells;
    longint unsigned m, g, target;
    longint          h, d, nh;
    logic [RATE_W-1:0] frac;
    cells = frame_length();
    if (cell_pos >= cells) cell_pos = 0;
    // byte widened to q0.16, then gated and stretched back to full scale
    m = longint'(motion) * 257;
    g = 0;
    if (m > gate_level) begin
      g = ((m - gate_level) * gate_gain_scale) >> 16;
      if (g > 65535) g = 65535;
    end
    target = (g * 15 * height_mult) >> 16;
    if (target > 65535) target = 65535;
    // attack when the target is above the stored height, release otherwise
    h = longint'(height_store[cell_pos]);
    frac = (longint'(target) > h) ? rise_frac : fall_frac;
    d = longint'(target) - h;
    nh = h + ((d * longint'(frac)) >>> 16);   // floor, toward minus infinity
    if (nh < 0) nh = 0;
    if (nh > 65535) nh = 65535;
    height_store[cell_pos] = nh[HEIGHT_W-1:0];
    gated_total = gated_total + g[SUM_W-1:0];
    w.column_height = (nh < HEIGHT_FLOOR) ? HEIGHT_FLOOR : nh[HEIGHT_W-1:0];
    if (cell_pos + 1 >= cells) begin
      w.frame_done = 1'b1;
      w.average_motion = MOTION_W'(gated_total / cells);
      cell_pos = 0;
      gated_total = '0;
    end else begin
      w.frame_done = 1'b0;
      w.average_motion = '0;
      cell_pos++;
    end
    return w;
  endfunction

  // ------------------------------------------------------------------ drivers

  // one register write; the predictor takes it at once since the core is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_GATE_THRESHOLD: gate_level = data[THRESH_W-1:0];
      CFG_GATE_SCALE:     gate_gain_scale = data[SCALE_W-1:0];
      CFG_HEIGHT_GAIN:    height_mult = data[GAIN_W-1:0];
      CFG_RISE_RATE:      rise_frac = data[RATE_W-1:0];
      CFG_FALL_RATE:      fall_frac = data[RATE_W-1:0];
      CFG_CELL_COUNT: begin
        cells_reg = data[CNT_W-1:0];
        clear_heights();
      end
      default: ;   // undecoded index, nothing changes
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one sample word; valid stays up after accept unless a gap or a drain follows
  task automatic send_sample(input logic [SAMPLE_W-1:0] motion);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_motion_sample <= motion;
    do @(posedge clk); while (!in_ready);
    expected_heights.push_back(predict_height(motion));
  endtask

  // sender holds off until every owed height has come back
  task automatic drain_heights();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
  endtask

  // register value: range ends, in range, or any 17-bit pattern
  function automatic logic [CFG_W-1:0] draw_setting(input int unsigned lo,
                                                    input int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return CFG_W'(lo);
      1:       return CFG_W'(hi);
      2:       return CFG_W'($urandom_range(0, 131071));
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // result side stalls in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("word %0d %s: got %0d, expected %0d (t=%0t)",
             words_checked, what, got, want, $time);
  endtask

  always @(posedge clk) begin : check_heights
    height_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("result with nothing owed", out_column_height, 0);
      end else begin
        want = expected_heights.pop_front();
        if (out_column_height !== want.column_height)
          report_mismatch("column_height", out_column_height, want.column_height);
        if (out_frame_done !== want.frame_done)
          report_mismatch("frame_done", out_frame_done, want.frame_done);
        if (out_average_motion !== want.average_motion)
          report_mismatch("average_motion", out_average_motion, want.average_motion);
      end
      words_checked++;
    end
  end

  // watchdog: too long without any word or write moving means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests

  // reset values: just below and just above the default gate, both byte ends
  task automatic test_reset_values();
    send_sample(8'd0);
    send_sample(8'd38);
    send_sample(8'd39);
    send_sample(8'd255);
  endtask

  // gate exactly at a sample level, scale below unity, saturating gate at full gain
  task automatic test_gate_and_scale();
    drain_heights();
    write_reg(CFG_GATE_THRESHOLD, CFG_W'(64 * 257));
    send_sample(8'd64);
    send_sample(8'd65);
    drain_heights();
    write_reg(CFG_GATE_SCALE, CFG_W'(30000));
    send_sample(8'd255);
    drain_heights();
    write_reg(CFG_GATE_THRESHOLD, CFG_W'(0));
    write_reg(CFG_GATE_SCALE, CFG_W'(131071));
    write_reg(CFG_HEIGHT_GAIN, CFG_W'(4095));
    send_sample(8'd255);
    send_sample(8'd1);
  endtask

  // count of zero acts as one, over the depth acts as the depth, short frame
  task automatic test_frame_length_limits();
    drain_heights();
    write_reg(CFG_CELL_COUNT, CFG_W'(0));
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd128);
    drain_heights();
    write_reg(CFG_CELL_COUNT, CFG_W'(8191));
    send_sample(8'd200);
    send_sample(8'd100);
    drain_heights();
    write_reg(CFG_CELL_COUNT, CFG_W'(3));
    send_sample(8'd10);
    send_sample(8'd20);
    send_sample(8'd30);
  endtask

  // full-scale and zero smoothing fractions on a two-cell frame
  task automatic test_rate_extremes();
    drain_heights();
    write_reg(CFG_CELL_COUNT, CFG_W'(2));
    write_reg(CFG_RISE_RATE, CFG_W'(65535));
    write_reg(CFG_FALL_RATE, CFG_W'(65535));
    send_sample(8'd255);
    send_sample(8'd0);
    drain_heights();
    write_reg(CFG_RISE_RATE, CFG_W'(0));
    write_reg(CFG_FALL_RATE, CFG_W'(0));
    send_sample(8'd255);
    send_sample(8'd0);
  endtask

  // undecoded indexes are dropped, wide data keeps only the register's bits
  task automatic test_register_decode();
    drain_heights();
    write_reg(CFG_UNUSED_LO, CFG_W'(131071));
    write_reg(CFG_UNUSED_HI, CFG_W'(0));
    write_reg(CFG_GATE_THRESHOLD, CFG_W'(131071));
    write_reg(CFG_RISE_RATE, CFG_W'(40000));
    write_reg(CFG_CELL_COUNT, CFG_W'(17'h1E005));
    send_sample(8'd128);
    send_sample(8'd255);
  endtask

  // random phases: fresh settings, then mostly whole frames of random motion
  task automatic test_random_frames();
    int sent;
    int cells;
    int count;
    int base;
    int pick;
    int kind;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_heights();
      idle_on = (sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) write_reg(CFG_GATE_THRESHOLD, draw_setting(0, 19661));
      if ($urandom_range(0, 9) < 6) write_reg(CFG_GATE_SCALE, draw_setting(65536, 93623));
      if ($urandom_range(0, 9) < 6) write_reg(CFG_HEIGHT_GAIN, draw_setting(0, 4095));
      if ($urandom_range(0, 9) < 6) write_reg(CFG_RISE_RATE, draw_setting(0, 65535));
      if ($urandom_range(0, 9) < 6) write_reg(CFG_FALL_RATE, draw_setting(0, 65535));
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                  CFG_W'($urandom_range(0, 131071)));
      // no count write keeps heights and position across the phase boundary
      if ($urandom_range(0, 9) < 7) begin
        kind = $urandom_range(0, 9);
        if (kind < 6)       cells = $urandom_range(1, 12);
        else if (kind < 8)  cells = $urandom_range(13, 64);
        else if (kind == 8) cells = $urandom_range(0, 1) ? 0 : MAX_CELLS;
        else                cells = $urandom_range(0, 131071);
        write_reg(CFG_CELL_COUNT, CFG_W'(cells));
      end
      cells = frame_length();
      // whole frames mostly, sometimes a broken frame tail
      if (cells <= 64)
        count = cells * $urandom_range(1, 4) +
                (($urandom_range(0, 3) == 0) ? $urandom_range(0, cells - 1) : 0);
      else
        count = $urandom_range(10, 40);
      if (count > 120) count = 120;
      for (int i = 0; i < count; i++) begin
        base = gate_level / 257;
        kind = $urandom_range(0, 19);
        if (kind < 5)       pick = $urandom_range(0, 255);
        else if (kind < 10) pick = base + int'($urandom_range(0, 4)) - 2;
        else if (kind < 13) pick = 0;
        else if (kind < 16) pick = 255;
        else                pick = $urandom_range(200, 255);
        if (pick < 0) pick = 0;
        if (pick > 255) pick = 255;
        send_sample(pick[SAMPLE_W-1:0]);
        // sender sometimes waits for every owed height mid-phase
        if (idle_on && $urandom_range(0, 60) == 0) drain_heights();
      end
      sent += count;
    end
  endtask

  // ----------------------------------------------------------------- sequence

  initial begin
    // predictor starts from the reset state
    gate_level      = RST_GATE_THRESHOLD;
    gate_gain_scale = RST_GATE_SCALE;
    height_mult     = RST_HEIGHT_GAIN;
    rise_frac       = RST_RISE_RATE;
    fall_frac       = RST_FALL_RATE;
    cells_reg       = RST_CELL_COUNT;
    clear_heights();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    test_reset_values();
    test_gate_and_scale();
    test_frame_length_limits();
    test_rate_extremes();
    test_register_decode();
    test_random_frames();

    // wait out owed heights, then a quiet tail for anything stray
    drain_heights();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_heights.size() != 0)
      report_mismatch("heights still owed", expected_heights.size(), 0);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/garhm_pkg.sv
hdl/garhm_ram.sv
hdl/garhm_div.sv
hdl/gated_attack_release_height_map_core.sv
verif/tb_gated_attack_release_height_map_core.sv
